// ===== rtl/salc_pkg.sv =====
`timescale 1ns / 1ps
package salc_pkg;
   localparam int MAX_WAYS_DEF = 8;
   localparam int MAX_SETS_DEF = 256;
   localparam int TAG_W = 64;
   localparam int AGE_W = 4;
   localparam logic [1:0] CSR_OFFSET_BITS = 2'd0;
   localparam logic [1:0] CSR_SET_BITS    = 2'd1;
   localparam logic [1:0] CSR_WAYS_USED   = 2'd2;
   typedef struct packed {
      logic [4:0] offset_bits;
      logic [3:0] index_bits;
      logic [3:0] ways_used;
   } cfg_type;
endpackage

// ===== rtl/salc_store.sv =====
`timescale 1ns / 1ps
module salc_store #(
   parameter int MAX_WAYS = salc_pkg::MAX_WAYS_DEF,
   parameter int MAX_SETS = salc_pkg::MAX_SETS_DEF,
   parameter int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
   input  logic clock,
   input  logic rd_en,
   input  logic [SET_W-1:0] rd_set,
   output logic [MAX_WAYS-1:0][salc_pkg::TAG_W-1:0] rd_tag,
   output logic [MAX_WAYS-1:0][salc_pkg::AGE_W+1:0] rd_meta,
   input  logic wr_en,
   input  logic [SET_W-1:0] wr_set,
   input  logic [MAX_WAYS-1:0] wr_tag_en,
   input  logic [salc_pkg::TAG_W-1:0] wr_tag,
   input  logic [MAX_WAYS-1:0][salc_pkg::AGE_W+1:0] wr_meta
);
   import salc_pkg::*;
   // meta = {valid, dirty, age}; one row per set
   logic [MAX_WAYS-1:0][TAG_W-1:0] tag_mem [MAX_SETS];
   logic [MAX_WAYS-1:0][AGE_W+1:0] meta_mem [MAX_SETS];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         meta_mem[wr_set] <= wr_meta;
         for (int w = 0; w < MAX_WAYS; w++) begin
            if (wr_tag_en[w]) tag_mem[wr_set][w] <= wr_tag;
         end
      end
      if (rd_en) begin
         rd_tag  <= tag_mem[rd_set];
         rd_meta <= meta_mem[rd_set];
      end
   end
endmodule

// ===== rtl/set_assoc_lru_cache_lookup.sv =====
`timescale 1ns / 1ps
// Set-associative write-back cache tag lookup with LRU age counters.
// Input: pulse req_start with req_func (0 read, 1 write) and req_address
// while busy is low; the beat is taken at that edge.
// Output: rsp_strobe is high for one cycle with rsp_hit, rsp_dirty_writeback
// and rsp_way_used. The receiver cannot stall; the result is simply shown.
// At the accepting edge the store registers the set row; in ST_READ it is
// compared, updated and written back, and the result registered; the strobe is
// high in ST_SHOW. Busy stays high while an access is in flight, set by the
// single read-modify-write of the set row, so none is taken until after the strobe.
// Config: csr_valid/csr_ready write offset_bits (0), set_bits (1) and
// ways_used (2); other indexes are dropped. Write only while idle.
// Reset: after reset a clearing pass writes every set row to invalid;
// busy is high during it, config writes still taken.
// Each row holds all ways of one set: tags plus {valid, dirty, age}.
module set_assoc_lru_cache_lookup #(
   parameter int MAX_WAYS = salc_pkg::MAX_WAYS_DEF,
   parameter int MAX_SETS = salc_pkg::MAX_SETS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_start,
   output logic        busy,
   input  logic        req_func,
   input  logic [63:0] req_address,
   output logic        rsp_strobe,
   output logic        rsp_hit,
   output logic        rsp_dirty_writeback,
   output logic [2:0]  rsp_way_used,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import salc_pkg::*;
   localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;
   localparam logic [1:0] ST_SHOW  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [SET_W:0] clr_ff, clr_in;
   cfg_type cfg_ff;
   logic func_ff;
   logic [SET_W-1:0] set_ff;
   logic [TAG_W-1:0] tag_ff;
   logic hit_ff, wb_ff;
   logic [2:0] way_ff;

   logic [MAX_WAYS-1:0][TAG_W-1:0] rd_tag;
   logic [MAX_WAYS-1:0][AGE_W+1:0] rd_meta, wr_meta;
   logic wr_en;
   logic [SET_W-1:0] wr_set;
   logic [MAX_WAYS-1:0] wr_tag_en;

   logic [4:0] eff_off;
   logic [3:0] eff_sb;
   logic [4:0] eff_ways;
   logic [63:0] sh, set_full, tag_full;
   logic accept;

   assign csr_ready = 1'b1;
   assign busy = (state_ff != ST_IDLE);
   assign accept = req_start && !busy;

   always_comb begin
      eff_off = (cfg_ff.offset_bits > 5'd16) ? 5'd16 : cfg_ff.offset_bits;
      eff_sb  = (cfg_ff.index_bits > 4'd8) ? 4'd8 : cfg_ff.index_bits;
      if (cfg_ff.ways_used == 4'd0) eff_ways = 5'd1;
      else if ({1'b0, cfg_ff.ways_used} > 5'(MAX_WAYS)) eff_ways = 5'(MAX_WAYS);
      else eff_ways = {1'b0, cfg_ff.ways_used};
      sh = req_address >> eff_off;
      set_full = sh & ((64'd1 << eff_sb) - 64'd1);
      tag_full = sh >> eff_sb;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{offset_bits: 5'd4, index_bits: 4'd8, ways_used: 4'd1};
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_OFFSET_BITS: cfg_ff.offset_bits <= csr_data[4:0];
            CSR_SET_BITS:    cfg_ff.index_bits  <= csr_data[3:0];
            CSR_WAYS_USED:   cfg_ff.ways_used   <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   salc_store #(.MAX_WAYS(MAX_WAYS), .MAX_SETS(MAX_SETS), .SET_W(SET_W)) u_store (
      .clock(clock), .rd_en(accept), .rd_set(set_full[SET_W-1:0]),
      .rd_tag(rd_tag), .rd_meta(rd_meta), .wr_en(wr_en), .wr_set(wr_set),
      .wr_tag_en(wr_tag_en), .wr_tag(tag_ff), .wr_meta(wr_meta));

   // Lookup and LRU update on the fetched row
   logic hit_c, inv_c, wb_c;
   logic [WAY_W-1:0] way_c, inv_way, old_way, hit_way;
   logic [AGE_W-1:0] best, a0;
   always_comb begin
      hit_c = 1'b0; inv_c = 1'b0; hit_way = '0; inv_way = '0;
      old_way = '0; best = rd_meta[0][AGE_W-1:0];
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (5'(w) < eff_ways) begin
            if (rd_meta[w][AGE_W+1] && rd_tag[w] == tag_ff) begin
               hit_c = 1'b1; hit_way = WAY_W'(w);
            end
         end
      end
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (5'(w) < eff_ways) begin
            if (!rd_meta[w][AGE_W+1]) begin
               inv_c = 1'b1; inv_way = WAY_W'(w);
            end
            if (rd_meta[w][AGE_W-1:0] > best) begin
               best = rd_meta[w][AGE_W-1:0]; old_way = WAY_W'(w);
            end
         end
      end
      way_c = hit_c ? hit_way : (inv_c ? inv_way : old_way);
      wb_c = !hit_c && !inv_c && rd_meta[old_way][AGE_W];
      a0 = rd_meta[way_c][AGE_W-1:0];
      wr_meta = rd_meta;
      wr_tag_en = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (5'(w) < eff_ways && rd_meta[w][AGE_W-1:0] <= a0 &&
             {1'b0, rd_meta[w][AGE_W-1:0]} < eff_ways)
            wr_meta[w][AGE_W-1:0] = rd_meta[w][AGE_W-1:0] + 1'b1;
      end
      wr_meta[way_c][AGE_W-1:0] = '0;
      wr_meta[way_c][AGE_W+1] = 1'b1;
      wr_meta[way_c][AGE_W] = hit_c ? (rd_meta[way_c][AGE_W] | func_ff) : func_ff;
      wr_tag_en[way_c] = !hit_c;
      wr_en = (state_ff == ST_READ);
      wr_set = set_ff;
      if (state_ff == ST_CLEAR) begin
         wr_en = 1'b1;
         wr_set = clr_ff[SET_W-1:0];
         wr_meta = '0;
         wr_tag_en = '0;
      end
   end

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (SET_W+1)'(MAX_SETS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: if (accept) state_in = ST_READ;
         ST_READ: state_in = ST_SHOW;
         ST_SHOW: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_func;
         set_ff <= set_full[SET_W-1:0];
         tag_ff <= tag_full;
      end
      if (state_ff == ST_READ) begin
         hit_ff <= hit_c;
         wb_ff <= wb_c;
         way_ff <= 3'(way_c);
      end
   end

   assign rsp_strobe = (state_ff == ST_SHOW);
   assign rsp_hit = hit_ff;
   assign rsp_dirty_writeback = wb_ff;
   assign rsp_way_used = way_ff;

`ifndef SYNTH
   a_strobe_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |=> rsp_strobe) else $error("no result after lookup");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy) else $error("result while idle");
   a_hit_no_wb: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_hit |-> !rsp_dirty_writeback) else $error("writeback on hit");
   a_way_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> {2'b0, rsp_way_used} < eff_ways || MAX_WAYS > 8)
      else $error("way out of range");
`endif
endmodule
